// ===== rtl/core/prdq_pkg.sv =====
`timescale 1ns / 1ps

package prdq_pkg;

  // Operation requested by one input item.
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_REMOVE     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_FRONT,
    S_POP_BACK,
    S_SCAN,
    S_SHIFT
  } state_t;

  // Where the id and handle of a result come from.
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_READ,
    SRC_SAVED
  } src_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] handle;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    push_front;
    logic    push_back;
    logic    rd_front;
    logic    rd_back;
    logic    pop_front;
    logic    pop_back;
    logic    scan_init;
    logic    scan_step;
    logic    shift_init;
    logic    shift_step;
    logic    remove_commit;
    logic    emit;
    status_t emit_status;
    src_t    emit_src;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic scan_done;
    logic shift_done;
  } stat_t;

endpackage

// ===== rtl/core/prdq_dp.sv =====
`timescale 1ns / 1ps

module prdq_dp #(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  prdq_pkg::cmd_t   cmd,
  input  logic [15:0]      in_proc_id,
  input  logic [15:0]      in_proc_handle,
  output prdq_pkg::stat_t  stat,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_id,
  output logic [15:0]      out_handle,
  output logic [5:0]       out_count
);
  import prdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  // Ring buffer: logical position 0 sits at head_r.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] lidx);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(lidx);
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[AW-1:0];
  endfunction

  entry_t mem [CAPACITY];

  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [15:0]   key_r;
  logic [CW-1:0] issue_r;
  logic          pend_r;
  logic [CW-1:0] pend_idx_r;
  logic [CW-1:0] src_r;
  logic          spend_r;
  logic [CW-1:0] wdst_r;
  entry_t        rd_q;
  entry_t        res_r;
  logic          out_valid_r;
  status_t       out_status_r;
  entry_t        out_entry_r;

  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic          issue_more;
  logic          src_more;
  logic          rd_en;
  logic [CW-1:0] rd_lidx;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] wr_lidx;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [CW+5:0] count_ext;

  assign head_dec   = (head_r == '0) ? LAST_A : head_r - AW'(1);
  assign head_inc   = (head_r == LAST_A) ? '0 : head_r + AW'(1);
  assign issue_more = issue_r < count_r;
  assign src_more   = src_r < count_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_lidx = '0;
    if (cmd.rd_front) begin
      rd_en = 1'b1;
    end else if (cmd.rd_back) begin
      rd_en   = 1'b1;
      rd_lidx = count_r - CW'(1);
    end else if (cmd.scan_step) begin
      rd_en   = issue_more;
      rd_lidx = issue_r;
    end else if (cmd.shift_step) begin
      rd_en   = src_more;
      rd_lidx = src_r;
    end
  end

  assign rd_addr = phys(head_r, rd_lidx);

  always_comb begin
    wr_en   = 1'b0;
    wr_lidx = wdst_r;
    wr_data = rd_q;
    if (cmd.push_front || cmd.push_back) begin
      wr_en   = 1'b1;
      wr_lidx = count_r;
      wr_data = '{id: in_proc_id, handle: in_proc_handle};
    end else if (cmd.shift_step && spend_r) begin
      wr_en = 1'b1;
    end
  end

  assign wr_addr = cmd.push_front ? head_dec : phys(head_r, wr_lidx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      spend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push_front) begin
        head_r <= head_dec;
      end else if (cmd.pop_front) begin
        head_r <= head_inc;
      end
      if (cmd.push_front || cmd.push_back) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop_front || cmd.pop_back || cmd.remove_commit) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.scan_init) begin
        pend_r <= 1'b0;
      end else if (cmd.scan_step) begin
        pend_r <= issue_more;
      end
      if (cmd.shift_init) begin
        spend_r <= 1'b0;
      end else if (cmd.shift_step) begin
        spend_r <= src_more;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r <= in_proc_id;
    end
    if (cmd.scan_init) begin
      issue_r <= '0;
    end else if (cmd.scan_step && issue_more) begin
      issue_r    <= issue_r + CW'(1);
      pend_idx_r <= issue_r;
    end
    if (cmd.shift_init) begin
      src_r <= pend_idx_r + CW'(1);
      res_r <= rd_q;
    end else if (cmd.shift_step && src_more) begin
      src_r  <= src_r + CW'(1);
      wdst_r <= src_r - CW'(1);
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      case (cmd.emit_src)
        SRC_READ:  out_entry_r <= rd_q;
        SRC_SAVED: out_entry_r <= res_r;
        default:   out_entry_r <= '0;
      endcase
    end
  end

  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == CAP_C);
  assign stat.hit        = pend_r && (rd_q.id == key_r);
  assign stat.scan_done  = !pend_r && !issue_more;
  assign stat.shift_done = !spend_r && !src_more;

  assign count_ext  = {6'd0, count_r};
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_entry_r.id;
  assign out_handle = out_entry_r.handle;
  assign out_count  = count_ext[5:0];

endmodule

// ===== rtl/core/prdq_ctrl.sv =====
`timescale 1ns / 1ps

module prdq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2:0]      in_kind,
  input  prdq_pkg::stat_t stat,
  output logic            busy,
  output prdq_pkg::cmd_t  cmd
);
  import prdq_pkg::*;

  state_t state_r;
  state_t state_nxt;
  kind_t  kind;
  logic   accept;

  assign kind   = kind_t'(in_kind);
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_POP_FRONT: if (!stat.empty) state_nxt = S_POP_FRONT;
            KIND_POP_BACK:  if (!stat.empty) state_nxt = S_POP_BACK;
            KIND_REMOVE:    state_nxt = S_SCAN;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP_FRONT: state_nxt = S_IDLE;
      S_POP_BACK:  state_nxt = S_IDLE;
      S_SCAN: begin
        if (stat.hit) begin
          state_nxt = S_SHIFT;
        end else if (stat.scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_PUSH_FRONT: begin
              cmd.emit = 1'b1;
              if (stat.full) begin
                cmd.emit_status = STAT_FULL;
              end else begin
                cmd.push_front = 1'b1;
              end
            end
            KIND_PUSH_BACK: begin
              cmd.emit = 1'b1;
              if (stat.full) begin
                cmd.emit_status = STAT_FULL;
              end else begin
                cmd.push_back = 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STAT_EMPTY;
              end else begin
                cmd.rd_front = 1'b1;
              end
            end
            KIND_POP_BACK: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STAT_EMPTY;
              end else begin
                cmd.rd_back = 1'b1;
              end
            end
            KIND_REMOVE: begin
              cmd.capture   = 1'b1;
              cmd.scan_init = 1'b1;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_POP_FRONT: begin
        cmd.pop_front = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_src  = SRC_READ;
      end
      S_POP_BACK: begin
        cmd.pop_back = 1'b1;
        cmd.emit     = 1'b1;
        cmd.emit_src = SRC_READ;
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.shift_init = 1'b1;
        end else if (stat.scan_done) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_NOT_FOUND;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.remove_commit = 1'b1;
          cmd.emit          = 1'b1;
          cmd.emit_src      = SRC_SAVED;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/process_ready_deque_top.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue of process entries (id and handle) for a
// scheduler ready queue. An item is taken when start is high and busy is low;
// its single result appears on the out_ ports for exactly one cycle with
// out_valid high, and it cannot be held off, so the receiver must take it in
// that cycle. The entries live in a ring buffer memory of CAPACITY words with
// one write and one registered read port. Pushes, refused pushes, pops from
// an empty queue and unknown kinds give their result in the cycle after the
// item is taken, so they run at one item per cycle. A pop needs one memory
// read, issued when the item is taken, and emits its entry from the pop
// state. A remove walks the memory front to back, one entry per cycle
// through the single read port, and then moves every entry behind the match
// down by one, again one per cycle. A hit gives the removed entry once the
// move is done; a miss gives a not-found status once the scan is done.
// out_count is the number of entries held after the item, taken modulo 64.
// No clearing pass is needed after reset, because only positions that hold
// live entries are ever read.

module process_ready_deque_top #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_proc_id,
  input  logic [15:0] in_proc_handle,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_id,
  output logic [15:0] out_handle,
  output logic [5:0]  out_count
);
  import prdq_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  cmd_t  cmd;
  stat_t stat;

  prdq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  prdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_proc_id     (in_proc_id),
    .in_proc_handle (in_proc_handle),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_handle     (out_handle),
    .out_count      (out_count)
  );

`ifndef SYNTHESIS
  // Every taken item either keeps the block busy or gives its result at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("item taken without result or busy");

  // The block leaves a multi-cycle operation only by giving a result.
  a_busy_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A result only ever follows a taken item or a busy cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a cause");

  // Failed operations never carry entry data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> ((out_id == '0) && (out_handle == '0)))
    else $error("failed operation returned entry data");
`endif

endmodule
